// ----- hw/rtl/sat_pkg.sv -----
// Shared types and constants for the security association table.
// Request, response and stored entry records, operation and status codes.
// No dependencies.
package sat_pkg;

    localparam int ENTRIES     = 32;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_INBOUND  = 2'd2;
    localparam logic [1:0] OP_OUTBOUND = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] handle;
        logic [31:0] spi;
        logic [31:0] iface_id;
        logic        sa_inbound;
        logic [30:0] tag_seq;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_handle;
        logic [30:0] found_tag;
        logic [31:0] out_seq;
    } t_rsp;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [31:0]            spi;
        logic [31:0]            iface;
        logic                   inbound;
        logic [30:0]            tag;
        logic [31:0]            counter;
    } t_entry;

endpackage

// ----- hw/rtl/security_association_table.sv -----
// Security association table: insert, delete and SPI / interface lookups.
// Entry records live in a one-port-read, one-port-write synchronous memory.
// Depends on sat_pkg.
//
//  channel  | valid      | ready       | payload
//  ---------+------------+-------------+-----------------------
//  request  | i_in_valid | o_in_ready  | i_in_data  (t_req)
//  response | o_out_valid| i_out_ready | o_out_data (t_rsp)
//
// One request at a time: the entry memory is scanned one entry per cycle in
// ascending order, stopping at the first match or at the last entry; the next
// request is taken once the result has moved to the response register.
// Reset clears the valid bits and the control state at once; no clearing pass.
// A response stalled at the output holds; the next request is taken while it
// waits, and its own response waits until the output register frees.
module security_association_table
    import sat_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    t_entry r_mem [ENTRIES];

    logic [1:0]          r_state, n_state;
    t_req                r_req;
    logic [IDX_BITS:0]   r_addr;
    logic                r_pend;
    logic [IDX_BITS-1:0] r_cidx;
    t_entry              r_rdata;
    logic [ENTRIES-1:0]  r_valid;
    logic                r_free_ok;
    logic [IDX_BITS-1:0] r_free_idx;
    t_rsp                r_res, n_res;
    t_rsp                r_out;
    logic                r_out_vld;

    logic                   in_xfer;
    logic                   rd_en;
    logic [HANDLE_BITS-1:0] key_h;
    logic [31:0]            key_h32;
    logic [31:0]            ent_h32;
    logic                   ent_v;
    logic                   hit;
    logic                   last;
    logic                   chk;
    logic                   done;
    logic                   free_any;
    logic [IDX_BITS-1:0]    free_idx;
    logic                   wr_en;
    logic [IDX_BITS-1:0]    wr_idx;
    t_entry                 wr_data;
    logic                   set_v;
    logic                   clr_v;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign rd_en   = (r_state == S_SCAN) && (r_addr < (IDX_BITS + 1)'(ENTRIES));
    assign key_h   = HANDLE_BITS'(32'(r_req.handle));
    assign key_h32 = 32'(key_h);
    assign ent_h32 = 32'(r_rdata.handle);
    assign ent_v   = r_valid[r_cidx];
    assign last    = (r_cidx == IDX_BITS'(ENTRIES - 1));
    assign chk     = (r_state == S_SCAN) && r_pend;
    assign done    = chk && (hit || last);

    assign free_any = r_free_ok || !ent_v;
    assign free_idx = r_free_ok ? r_free_idx : r_cidx;

    always_comb begin
        case (r_req.operation)
            OP_INSERT, OP_DELETE: hit = ent_v && (r_rdata.handle == key_h);
            OP_INBOUND:  hit = ent_v && (r_req.spi != 32'd0) && (r_rdata.spi == r_req.spi);
            OP_OUTBOUND: hit = ent_v && !r_rdata.inbound && (r_req.iface_id != 32'd0)
                               && (r_rdata.iface == r_req.iface_id);
            default:     hit = 1'b0;
        endcase
    end

    always_comb begin
        n_res        = '0;
        n_res.status = ST_NONE;
        wr_en        = 1'b0;
        wr_idx       = r_cidx;
        wr_data      = r_rdata;
        set_v        = 1'b0;
        clr_v        = 1'b0;
        if (chk && hit) begin
            n_res.status       = ST_OK;
            n_res.found_handle = ent_h32[15:0];
            n_res.found_tag    = r_rdata.tag;
            case (r_req.operation)
                OP_INSERT: begin
                    n_res.status = ST_DUP;
                end
                OP_DELETE: begin
                    clr_v = 1'b1;
                end
                OP_OUTBOUND: begin
                    n_res.out_seq   = r_rdata.counter;
                    wr_en           = 1'b1;
                    wr_data.counter = r_rdata.counter + 32'd1;
                end
                default: begin
                end
            endcase
        end else if (chk && last && (r_req.operation == OP_INSERT)) begin
            if (free_any) begin
                n_res.status       = ST_OK;
                n_res.found_handle = key_h32[15:0];
                n_res.found_tag    = r_req.tag_seq;
                wr_en              = 1'b1;
                wr_idx             = free_idx;
                wr_data.handle     = key_h;
                wr_data.spi        = r_req.spi;
                wr_data.iface      = r_req.iface_id;
                wr_data.inbound    = r_req.sa_inbound;
                wr_data.tag        = r_req.tag_seq;
                wr_data.counter    = 32'd1;
                set_v              = 1'b1;
            end else begin
                n_res.status = ST_FULL;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_xfer) n_state = S_SCAN;
            S_SCAN: if (done) n_state = S_DONE;
            S_DONE: if (!r_out_vld || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_addr[IDX_BITS-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_in_data;
        end
        if (rd_en) begin
            r_cidx <= r_addr[IDX_BITS-1:0];
        end
        if (chk && !r_free_ok && !ent_v) begin
            r_free_idx <= r_cidx;
        end
        if (done) begin
            r_res <= n_res;
        end
        if ((r_state == S_DONE) && (!r_out_vld || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_free_ok <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_addr    <= '0;
                r_pend    <= 1'b0;
                r_free_ok <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_addr <= r_addr + (IDX_BITS + 1)'(1);
                end
                r_pend <= rd_en;
                if (chk && !ent_v) begin
                    r_free_ok <= 1'b1;
                end
            end
            if (set_v) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (clr_v) begin
                r_valid[r_cidx] <= 1'b0;
            end
            if ((r_state == S_DONE) && (!r_out_vld || i_out_ready)) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/sat_checker.sv -----
// Port-level checks for the security association table.
// Watches the request and response channels; bound to the top level below.
// Depends on sat_pkg.
module sat_checker
    import sat_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken during a scan");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_NONE || o_out_data.status == ST_FULL)
        |-> o_out_data.found_handle == 16'd0 && o_out_data.found_tag == 31'd0
            && o_out_data.out_seq == 32'd0)
        else $error("miss response carries entry fields");

    a_seq_outbound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_seq != 32'd0 |-> o_out_data.status == ST_OK)
        else $error("sequence value on a failed response");

endmodule

bind security_association_table sat_checker u_sat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
